// ===== rtl/icsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the serial programming frame engine.
package icsp_pkg;

	localparam int CMD_MAX_BITS_DEF   = 8;
	localparam int LONG_WORD_BITS_DEF = 24;

	localparam int FUNC_W    = 3;
	localparam int CMD_LEN_W = 4;
	localparam int CMD_W     = 8;
	localparam int PAYLOAD_W = 24;
	localparam int CNT_W     = 6;
	localparam int WAIT_W    = 8;
	localparam int RD_W      = 16;
	localparam int RD_POS_W  = 4;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// frame lengths in bits
	localparam int WORD16_BITS = 16;
	localparam int WORD14_BITS = 14;
	localparam int READ14_BITS = 14;
	localparam int BYTE_BITS   = 8;
	localparam int READ16_BITS = 16;
	localparam int W14_PRE_BITS  = 1;
	localparam int RB_PRE_BITS   = 8;
	localparam int DS24_PRE_BITS = 4;
	localparam int DS16_PRE_BITS = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN = 1'b1;

	localparam logic [WAIT_W-1:0] GAP_RESET  = 8'd2;
	localparam logic [WAIT_W-1:0] TURN_RESET = 8'd2;

	typedef enum logic [FUNC_W-1:0] {
		FN_CMD   = 3'd0,
		FN_W16   = 3'd1,
		FN_W14   = 3'd2,
		FN_R14   = 3'd3,
		FN_RBYTE = 3'd4,
		FN_DS24  = 3'd5,
		FN_DS16  = 3'd6,
		FN_TICK  = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_CMD  = 4'd1,
		PH_GAP  = 4'd2,
		PH_PRE  = 4'd3,
		PH_SEND = 4'd4,
		PH_POST = 4'd5,
		PH_TURN = 4'd6,
		PH_DIN  = 4'd7,
		PH_READ = 4'd8,
		PH_DOUT = 4'd9
	} phase_t;

	typedef struct packed {
		func_t                  func;
		logic [CMD_LEN_W-1:0]   cmd_length;
		logic [CMD_W-1:0]       cmd_bits;
		logic [PAYLOAD_W-1:0]   payload;
		logic                   pgd_in;
	} item_t;

	typedef struct packed {
		logic            pgc_level;
		logic            pgd_level;
		logic            pgd_drive;
		logic            busy_res;
		logic            done_res;
		logic [RD_W-1:0] read_data;
		logic            rejected;
	} result_t;

	typedef struct packed {
		logic [WAIT_W-1:0] gap_ticks;
		logic [WAIT_W-1:0] turnaround_ticks;
	} cfg_t;

endpackage

// ===== rtl/icsp_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: post-command gap and read turnaround.
module icsp_cfg_regs
	import icsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	logic [WAIT_W-1:0] gap_q;
	logic [WAIT_W-1:0] turn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= GAP_RESET;
			turn_q <= TURN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAP:  gap_q  <= cfg_data;
				CFG_TURN: turn_q <= cfg_data;
			endcase
		end
	end

	assign cfg.gap_ticks        = gap_q;
	assign cfg.turnaround_ticks = turn_q;

endmodule

// ===== rtl/icsp_frame_core.sv =====
`timescale 1ns / 1ps
// Frame sequencer: phase state, shift registers and pin levels, one beat per step.
module icsp_frame_core
	import icsp_pkg::*;
#(
	parameter int CMD_MAX_BITS   = CMD_MAX_BITS_DEF,
	parameter int LONG_WORD_BITS = LONG_WORD_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	func_t                    kind_q, kind_d;
	phase_t                   phase_q, phase_d;
	logic [CNT_W-1:0]         bit_cnt_q, bit_cnt_d;
	logic                     half_q, half_d;
	logic [WAIT_W-1:0]        wait_q, wait_d;
	logic [CMD_W-1:0]         cmd_sh_q, cmd_sh_d;
	logic [LONG_WORD_BITS-1:0] data_sh_q, data_sh_d;
	logic [RD_W-1:0]          rd_sh_q, rd_sh_d;
	logic                     pgc_q, pgc_d;
	logic                     pgd_q, pgd_d;
	logic                     adv, done, rej;
	logic [CMD_LEN_W-1:0]     len_sat;

	function automatic phase_t next_phase(input func_t k, input phase_t p);
		phase_t n;
		n = PH_IDLE;
		unique case (p)
			PH_CMD: n = PH_GAP;
			PH_GAP: begin
				case (k) inside
					FN_CMD:                    n = PH_IDLE;
					FN_W16:                    n = PH_SEND;
					FN_R14:                    n = PH_TURN;
					FN_W14, FN_RBYTE, FN_DS24, FN_DS16: n = PH_PRE;
					default:                   n = PH_IDLE;
				endcase
			end
			PH_PRE: begin
				case (k) inside
					FN_W14, FN_DS24:  n = PH_SEND;
					FN_RBYTE, FN_DS16: n = PH_TURN;
					default:          n = PH_IDLE;
				endcase
			end
			PH_SEND: n = (k == FN_W14) ? PH_POST : PH_IDLE;
			PH_TURN: begin
				case (k) inside
					FN_R14:            n = PH_DIN;
					FN_RBYTE, FN_DS16: n = PH_READ;
					default:           n = PH_IDLE;
				endcase
			end
			PH_DIN:  n = (k == FN_R14) ? PH_READ : PH_IDLE;
			PH_READ: n = (k == FN_R14) ? PH_DOUT : PH_IDLE;
			default: n = PH_IDLE;
		endcase
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] read_len(input func_t k);
		logic [CNT_W-1:0] r;
		r = (k == FN_R14) ? CNT_W'(READ14_BITS)
		  : (k == FN_RBYTE) ? CNT_W'(BYTE_BITS) : CNT_W'(READ16_BITS);
		return r;
	endfunction

	assign len_sat = (item.cmd_length > CMD_LEN_W'(CMD_MAX_BITS))
	               ? CMD_LEN_W'(CMD_MAX_BITS) : item.cmd_length;

	always_comb begin
		phase_t               nxt;
		logic [CNT_W-1:0]     pos_full;
		kind_d    = kind_q;
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		half_d    = half_q;
		wait_d    = wait_q;
		cmd_sh_d  = cmd_sh_q;
		data_sh_d = data_sh_q;
		rd_sh_d   = rd_sh_q;
		pgc_d     = pgc_q;
		pgd_d     = pgd_q;
		adv       = 1'b0;
		done      = 1'b0;
		rej       = 1'b0;
		nxt       = PH_IDLE;
		pos_full  = read_len(kind_q) - bit_cnt_q;

		if (step) begin
			if (item.func != FN_TICK) begin
				if (phase_q != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					kind_d    = item.func;
					cmd_sh_d  = item.cmd_bits;
					data_sh_d = LONG_WORD_BITS'(item.payload);
					if (item.func == FN_R14 || item.func == FN_RBYTE || item.func == FN_DS16)
						rd_sh_d = '0;
					pgc_d     = 1'b0;
					pgd_d     = 1'b0;
					phase_d   = PH_CMD;
					half_d    = 1'b0;
					bit_cnt_d = CNT_W'(len_sat);
					adv       = (len_sat == '0);
				end
			end else if (phase_q != PH_IDLE) begin
				if (phase_q == PH_GAP || phase_q == PH_TURN) begin
					pgc_d = 1'b0;
					if (wait_q != '0)
						wait_d = wait_q - 1'b1;
					adv = (wait_d == '0);
				end else if (!half_q) begin
					// rising clock: present the bit, sample on reads
					pgc_d = 1'b1;
					case (phase_q) inside
						PH_CMD, PH_PRE: pgd_d = cmd_sh_q[0];
						PH_SEND:        pgd_d = data_sh_q[0];
						PH_POST:        pgd_d = 1'b0;
						PH_READ: begin
							if (item.pgd_in)
								rd_sh_d[pos_full[RD_POS_W-1:0]] = 1'b1;
						end
						default: ;
					endcase
					half_d = 1'b1;
				end else begin
					pgc_d  = 1'b0;
					half_d = 1'b0;
					case (phase_q) inside
						PH_CMD, PH_PRE: cmd_sh_d  = cmd_sh_q >> 1;
						PH_SEND:        data_sh_d = data_sh_q >> 1;
						default: ;
					endcase
					if (bit_cnt_q != '0)
						bit_cnt_d = bit_cnt_q - 1'b1;
					adv = (bit_cnt_d == '0);
				end
			end
		end

		if (adv) begin
			// skip empty wait phases; at most gap then turnaround
			nxt = next_phase(kind_d, phase_d);
			if (nxt == PH_GAP && cfg.gap_ticks == '0)
				nxt = next_phase(kind_d, nxt);
			if (nxt == PH_TURN && cfg.turnaround_ticks == '0)
				nxt = next_phase(kind_d, nxt);
			phase_d = nxt;
			half_d  = 1'b0;
			pgc_d   = 1'b0;
			case (nxt)
				PH_IDLE: begin
					pgd_d = 1'b0;
					done  = 1'b1;
				end
				PH_GAP:  wait_d = cfg.gap_ticks;
				PH_TURN: wait_d = cfg.turnaround_ticks;
				PH_PRE: begin
					cmd_sh_d  = (kind_d == FN_DS16) ? CMD_W'(1) : '0;
					bit_cnt_d = (kind_d == FN_W14) ? CNT_W'(W14_PRE_BITS)
					          : (kind_d == FN_RBYTE) ? CNT_W'(RB_PRE_BITS)
					          : (kind_d == FN_DS24) ? CNT_W'(DS24_PRE_BITS)
					          : CNT_W'(DS16_PRE_BITS);
				end
				PH_SEND: begin
					bit_cnt_d = (kind_d == FN_W16) ? CNT_W'(WORD16_BITS)
					          : (kind_d == FN_W14) ? CNT_W'(WORD14_BITS)
					          : CNT_W'(LONG_WORD_BITS);
				end
				PH_READ: bit_cnt_d = read_len(kind_d);
				default: bit_cnt_d = CNT_W'(1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= FN_CMD;
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			half_q    <= 1'b0;
			wait_q    <= '0;
			cmd_sh_q  <= '0;
			data_sh_q <= '0;
			rd_sh_q   <= '0;
			pgc_q     <= 1'b0;
			pgd_q     <= 1'b0;
		end else begin
			kind_q    <= kind_d;
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			half_q    <= half_d;
			wait_q    <= wait_d;
			cmd_sh_q  <= cmd_sh_d;
			data_sh_q <= data_sh_d;
			rd_sh_q   <= rd_sh_d;
			pgc_q     <= pgc_d;
			pgd_q     <= pgd_d;
		end
	end

	assign res.pgc_level = pgc_d;
	assign res.pgd_level = pgd_d;
	assign res.pgd_drive = !(phase_d == PH_TURN || phase_d == PH_DIN ||
	                         phase_d == PH_READ || phase_d == PH_DOUT);
	assign res.busy_res  = (phase_d != PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = rd_sh_d;
	assign res.rejected  = rej;

`ifndef NO_ASSERTIONS
	a_wait_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_GAP || phase_q == PH_TURN) |-> wait_q != '0)
		else $error("wait phase entered with zero count");
	a_bits_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE && phase_q != PH_GAP && phase_q != PH_TURN) |-> bit_cnt_q != '0)
		else $error("bit phase with zero bit count");
	a_clk_half: assert property (@(posedge clk) disable iff (!arst_n)
		pgc_q == half_q)
		else $error("clock level out of step with half bit");
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !pgc_q && !pgd_q)
		else $error("pins not parked low while idle");
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && rej |=> phase_q == $past(phase_q) && wait_q == $past(wait_q))
		else $error("rejected request changed frame state");
`endif

endmodule

// ===== rtl/icsp_out_reg.sv =====
`timescale 1ns / 1ps
// Result register on the master side; refills in the cycle it is taken.
module icsp_out_reg
	import icsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  result_t                res,
	output logic                   room,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	result_t res_q;
	logic    vld_q;

	assign room = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (room) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tlast  = res_q.done_res;
	assign m_tdata  = {3'b000, res_q.rejected, res_q.read_data, res_q.busy_res,
	                   res_q.pgd_drive, res_q.pgd_level, res_q.pgc_level};

endmodule

// ===== rtl/icsp_serial_frame_engine.sv =====
`timescale 1ns / 1ps
// Serial programming-port master: top level with input register and result register.
//
// Slave side carries one request or tick per beat; tuser selects the function
// (request forms 0..6, tick 7). A request starts a frame: command bits LSB first,
// a gap, then the payload or read phase of the chosen form. A tick advances one
// half bit period; the data pin is sampled on ticks that raise the clock in a read.
// Every slave beat yields exactly one master beat with the pin levels, busy flag,
// read word and reject flag; tlast marks the beat on which a frame ended.
// A slave beat is taken by the input register; the sequencer logic then writes the
// result register, and m_tvalid rises when it is written. Throughput is one beat
// per cycle while the master side accepts, limited by the single-step sequencer
// that updates frame state once per beat.
// When the master side stalls, the result register and input register hold and
// s_tready drops once both are full; nothing is dropped.
// Reset clears the frame state to idle, both pins low, read word zero, and sets
// gap and turnaround to 2 ticks. Write configuration only while no beat is in flight.
module icsp_serial_frame_engine
	import icsp_pkg::*;
#(
	parameter int CMD_MAX_BITS   = CMD_MAX_BITS_DEF,
	parameter int LONG_WORD_BITS = LONG_WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [3:0] cmd_length, [11:4] cmd_bits, [35:12] payload, [36] pgd_in, [39:37] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [2:0] func
	input  logic [FUNC_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] pgc_level, [1] pgd_level, [2] pgd_drive, [3] busy_res,
	// [19:4] read_data, [20] rejected, [23:21] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// done_res
	output logic                   m_tlast
);

	item_t   item_s1;
	logic    vld_s1;
	logic    room;
	logic    step;
	cfg_t    cfg;
	result_t res;

	assign step     = vld_s1 && room;
	assign s_tready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func       <= func_t'(s_tuser);
			item_s1.cmd_length <= s_tdata[3:0];
			item_s1.cmd_bits   <= s_tdata[11:4];
			item_s1.payload    <= s_tdata[35:12];
			item_s1.pgd_in     <= s_tdata[36];
		end
	end

	icsp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	icsp_frame_core #(
		.CMD_MAX_BITS   (CMD_MAX_BITS),
		.LONG_WORD_BITS (LONG_WORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	icsp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== bench/tb_icsp_serial_frame_engine.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the serial programming frame engine: frames, ticks, stalls, config.
module tb_icsp_serial_frame_engine;
	import icsp_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [3:0] cmd_length, [11:4] cmd_bits, [35:12] payload, [36] pgd_in, [39:37] zero
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// [2:0] func
	logic [FUNC_W-1:0]      s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] pgc_level, [1] pgd_level, [2] pgd_drive, [3] busy_res,
	// [19:4] read_data, [20] rejected, [23:21] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	// done_res
	logic                   m_tlast;

	icsp_serial_frame_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// engine state as predicted by the bench
	logic [WAIT_W-1:0]    gap_cfg   = GAP_RESET;
	logic [WAIT_W-1:0]    turn_cfg  = TURN_RESET;
	func_t                eng_kind  = FN_CMD;
	phase_t               eng_phase = PH_IDLE;
	logic [CNT_W-1:0]     bits_left = '0;
	logic                 half_bit  = 1'b0;
	logic [WAIT_W-1:0]    wait_left = '0;
	logic [CMD_W-1:0]     cmd_sr    = '0;
	logic [PAYLOAD_W-1:0] word_sr   = '0;
	logic [RD_W-1:0]      rd_word   = '0;
	logic                 pin_clk   = 1'b0;
	logic                 pin_dat   = 1'b0;

	result_t expected_pins_q[$];

	int  mismatches   = 0;
	int  items_sent   = 0;
	int  results_seen = 0;
	int  frames_run   = 0;
	int  frames_ended = 0;
	int  rejects_seen = 0;
	bit  send_idle_on = 1'b1;
	bit  recv_idle_on = 1'b1;
	int  hold_left    = 0;
	int  stall_left   = 0;

	function automatic phase_t next_of(func_t k, phase_t p);
		case (p)
			PH_CMD: return PH_GAP;
			PH_GAP: begin
				case (k)
					FN_W16: return PH_SEND;
					FN_R14: return PH_TURN;
					FN_W14, FN_RBYTE, FN_DS24, FN_DS16: return PH_PRE;
					default: return PH_IDLE;
				endcase
			end
			PH_PRE:  return (k == FN_W14 || k == FN_DS24) ? PH_SEND : PH_TURN;
			PH_SEND: return (k == FN_W14) ? PH_POST : PH_IDLE;
			PH_TURN: return (k == FN_R14) ? PH_DIN : PH_READ;
			PH_DIN:  return PH_READ;
			PH_READ: return (k == FN_R14) ? PH_DOUT : PH_IDLE;
			default: return PH_IDLE;
		endcase
	endfunction

	function int read_bits();
		if (eng_kind == FN_R14) return READ14_BITS;
		if (eng_kind == FN_RBYTE) return BYTE_BITS;
		return READ16_BITS;
	endfunction

	// Move past empty phases; returns 1 when the frame is over.
	function bit enter_next_phase();
		bit fin;
		bit stop;
		fin = 1'b0;
		stop = 1'b0;
		while (!stop) begin
			eng_phase = next_of(eng_kind, eng_phase);
			half_bit = 1'b0;
			pin_clk = 1'b0;
			stop = 1'b1;
			case (eng_phase)
				PH_IDLE: begin
					pin_dat = 1'b0;
					fin = 1'b1;
				end
				PH_GAP: begin
					wait_left = gap_cfg;
					stop = (wait_left != 0);
				end
				PH_TURN: begin
					wait_left = turn_cfg;
					stop = (wait_left != 0);
				end
				PH_PRE: begin
					cmd_sr = (eng_kind == FN_DS16) ? 8'd1 : 8'd0;
					case (eng_kind)
						FN_W14:   bits_left = CNT_W'(W14_PRE_BITS);
						FN_RBYTE: bits_left = CNT_W'(RB_PRE_BITS);
						FN_DS24:  bits_left = CNT_W'(DS24_PRE_BITS);
						default:  bits_left = CNT_W'(DS16_PRE_BITS);
					endcase
				end
				PH_SEND: begin
					case (eng_kind)
						FN_W16:  bits_left = CNT_W'(WORD16_BITS);
						FN_W14:  bits_left = CNT_W'(WORD14_BITS);
						default: bits_left = CNT_W'(LONG_WORD_BITS_DEF);
					endcase
				end
				PH_READ: bits_left = CNT_W'(read_bits());
				default: bits_left = CNT_W'(1);
			endcase
		end
		return fin;
	endfunction

	function result_t engine_step(item_t it);
		result_t r;
		bit      fin;
		bit      rej;
		int      pos;
		fin = 1'b0;
		rej = 1'b0;
		if (it.func != FN_TICK) begin
			if (eng_phase != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				eng_kind = it.func;
				cmd_sr = it.cmd_bits;
				word_sr = it.payload;
				if (it.func == FN_R14 || it.func == FN_RBYTE || it.func == FN_DS16)
					rd_word = '0;
				pin_clk = 1'b0;
				pin_dat = 1'b0;
				eng_phase = PH_CMD;
				half_bit = 1'b0;
				bits_left = (it.cmd_length > CMD_MAX_BITS_DEF) ? CNT_W'(CMD_MAX_BITS_DEF)
					: CNT_W'(it.cmd_length);
				if (bits_left == 0)
					fin = enter_next_phase();
			end
		end else if (eng_phase != PH_IDLE) begin
			if (eng_phase == PH_GAP || eng_phase == PH_TURN) begin
				pin_clk = 1'b0;
				if (wait_left != 0)
					wait_left--;
				if (wait_left == 0)
					fin = enter_next_phase();
			end else if (!half_bit) begin
				pin_clk = 1'b1;
				case (eng_phase)
					PH_CMD, PH_PRE: pin_dat = cmd_sr[0];
					PH_SEND: pin_dat = word_sr[0];
					PH_POST: pin_dat = 1'b0;
					PH_READ: begin
						pos = read_bits() - int'(bits_left);
						if (it.pgd_in)
							rd_word[pos[3:0]] = 1'b1;
					end
					default: ;
				endcase
				half_bit = 1'b1;
			end else begin
				pin_clk = 1'b0;
				half_bit = 1'b0;
				if (eng_phase == PH_CMD || eng_phase == PH_PRE)
					cmd_sr = cmd_sr >> 1;
				else if (eng_phase == PH_SEND)
					word_sr = word_sr >> 1;
				if (bits_left != 0)
					bits_left--;
				if (bits_left == 0)
					fin = enter_next_phase();
			end
		end
		r.pgc_level = pin_clk;
		r.pgd_level = pin_dat;
		r.pgd_drive = !(eng_phase == PH_TURN || eng_phase == PH_DIN
			|| eng_phase == PH_READ || eng_phase == PH_DOUT);
		r.busy_res  = (eng_phase != PH_IDLE);
		r.done_res  = fin;
		r.read_data = rd_word;
		r.rejected  = rej;
		return r;
	endfunction

	function automatic int pick_len(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 15);
		if (r < 10)
			return 0;
		if (r < 15)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t make_tick(int pgd_mode);
		item_t it;
		it.func       = FN_TICK;
		it.cmd_length = CMD_LEN_W'($urandom_range(0, 15));
		it.cmd_bits   = CMD_W'($urandom_range(0, 255));
		it.payload    = PAYLOAD_W'($urandom);
		it.pgd_in     = (pgd_mode == 0) ? 1'b0 : (pgd_mode == 1) ? 1'b1
			: 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t rand_request();
		item_t it;
		it = make_tick(2);
		it.func = func_t'($urandom_range(0, 6));
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int g;
		g = pick_len(send_idle_on);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, it.pgd_in, it.payload, it.cmd_bits, it.cmd_length};
		s_tuser  <= it.func;
		do @(posedge clk); while (!s_tready);
		expected_pins_q.push_back(engine_step(it));
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_pins_q.size() != 0);
	endtask

	// Registers change only with nothing in flight and the frame finished.
	task automatic set_config(input logic [WAIT_W-1:0] gap, input logic [WAIT_W-1:0] turn);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_GAP;
		cfg_data  <= gap;
		@(posedge clk);
		cfg_index <= CFG_TURN;
		cfg_data  <= turn;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gap_cfg  = gap;
		turn_cfg = turn;
	endtask

	// One request, then ticks until the frame ends; busy requests mixed in at reject_pct.
	task automatic run_frame(input func_t f, input logic [3:0] len, input logic [7:0] cmd,
			input logic [23:0] word, input int pgd_mode, input int reject_pct,
			input int pause_after);
		item_t it;
		int    n;
		it = make_tick(2);
		it.func       = f;
		it.cmd_length = len;
		it.cmd_bits   = cmd;
		it.payload    = word;
		send_item(it);
		frames_run++;
		n = 0;
		while (eng_phase != PH_IDLE) begin
			if (reject_pct > 0 && $urandom_range(0, 99) < reject_pct)
				send_item(rand_request());
			else
				send_item(make_tick(pgd_mode));
			n++;
			if (n == pause_after)
				drain_results();
		end
	endtask

	function automatic logic [23:0] pick_word();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return 24'h000000;
		if (r == 1)
			return 24'hFFFFFF;
		return 24'($urandom);
	endfunction

	task automatic test_idle_ticks();
		send_item(make_tick(0));
		send_item(make_tick(1));
		repeat (3) send_item(make_tick(2));
	endtask

	task automatic test_each_form();
		run_frame(FN_CMD,   4'd15, 8'hFF, 24'h000000, 2, 0, 0);
		run_frame(FN_W16,   4'd2,  8'h02, 24'hFFFFFF, 2, 0, 0);
		run_frame(FN_W14,   4'd1,  8'h01, 24'h003FFF, 2, 0, 0);
		run_frame(FN_R14,   4'd3,  8'h05, 24'h123456, 1, 0, 0);
		run_frame(FN_RBYTE, 4'd1,  8'h01, 24'h000000, 0, 0, 0);
		run_frame(FN_DS24,  4'd1,  8'h01, 24'hFFFFFF, 2, 0, 0);
		run_frame(FN_DS16,  4'd2,  8'h02, 24'hA5A5A5, 2, 0, 0);
	endtask

	task automatic test_busy_reject();
		run_frame(FN_W14, 4'd2, 8'hA5, 24'h2AAAAA, 2, 30, 0);
	endtask

	task automatic test_empty_phases();
		set_config(8'd0, 8'd0);
		run_frame(FN_CMD,  4'd0, 8'hFF, 24'hFFFFFF, 2, 0, 0);
		run_frame(FN_R14,  4'd0, 8'h00, 24'h0, 2, 0, 0);
	endtask

	task automatic test_config_extremes();
		set_config(8'd64, 8'd0);
		run_frame(FN_CMD, 4'd1, 8'h01, 24'h0, 2, 5, 0);
		set_config(8'd1, 8'd1);
		run_frame(FN_R14, 4'd3, 8'h05, 24'h0, 2, 0, 0);
	endtask

	// Receiver holds off long enough that the input stalls; then a mid-frame pause.
	task automatic test_stall_and_drain();
		set_config(8'd3, 8'd2);
		send_idle_on = 1'b0;
		hold_left = 150;
		run_frame(FN_W16, 4'd2, 8'hC3, 24'h5A5A5A, 2, 10, 0);
		send_idle_on = 1'b1;
		run_frame(FN_W14, 4'd1, 8'h1F, 24'h00F00F, 2, 0, 12);
	endtask

	task automatic test_random_frames();
		logic [7:0]  g;
		logic [7:0]  t;
		logic [3:0]  len;
		while (items_sent < 650) begin
			if ($urandom_range(0, 2) == 0) begin
				g = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
				t = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
				if ($urandom_range(0, 9) == 0)
					g = 8'($urandom_range(20, 40));
				set_config(g, t);
			end
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) send_item(make_tick(2));
			len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			run_frame(func_t'($urandom_range(0, 6)), len, 8'($urandom_range(0, 255)),
				pick_word(), $urandom_range(0, 2),
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20), 0);
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = pick_len(1'b1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.pgc_level = m_tdata[0];
			got.pgd_level = m_tdata[1];
			got.pgd_drive = m_tdata[2];
			got.busy_res  = m_tdata[3];
			got.read_data = m_tdata[19:4];
			got.rejected  = m_tdata[20];
			got.done_res  = m_tlast;
			if (expected_pins_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none actual %h", $time, got);
			end else begin
				want = expected_pins_q.pop_front();
				check_field("pgc_level", 16'(want.pgc_level), 16'(got.pgc_level));
				check_field("pgd_level", 16'(want.pgd_level), 16'(got.pgd_level));
				check_field("pgd_drive", 16'(want.pgd_drive), 16'(got.pgd_drive));
				check_field("busy_res",  16'(want.busy_res),  16'(got.busy_res));
				check_field("done_res",  16'(want.done_res),  16'(got.done_res));
				check_field("read_data", want.read_data, got.read_data);
				check_field("rejected",  16'(want.rejected),  16'(got.rejected));
				results_seen++;
				if (want.done_res)
					frames_ended++;
				if (want.rejected)
					rejects_seen++;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_each_form();
		test_busy_reject();
		test_empty_phases();
		test_config_extremes();
		test_stall_and_drain();
		test_random_frames();
		drain_results();
		repeat (10) @(posedge clk);
		if (expected_pins_q.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived", $time, expected_pins_q.size());
		end
		$display("Ran %0d frames in %0d beats, %0d beats checked.",
			frames_run, items_sent, results_seen);
		$display("Saw %0d frame ends and %0d busy rejects; gap/turnaround from 0 to 64.",
			frames_ended, rejects_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", expected_pins_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== icsp_serial_frame_engine.f =====
rtl/icsp_pkg.sv
rtl/icsp_cfg_regs.sv
rtl/icsp_frame_core.sv
rtl/icsp_out_reg.sv
rtl/icsp_serial_frame_engine.sv
bench/tb_icsp_serial_frame_engine.sv
